// ===== rtl/sbc_pkg.sv =====
// Shared types and constants for the color-keyed sprite blitter.
// No dependencies; used by the front end, the back end and the top level.
`timescale 1ns / 1ps

package sbc_pkg;

    localparam int unsigned SX_W   = 10;  // origin_x (9b) + column (8b)
    localparam int unsigned SY_W   = 9;   // origin_y (8b) + row (8b)
    localparam int unsigned ADDR_W = 16;

    localparam logic [7:0] TRANSPARENT_COLOR = 8'hff;

    typedef enum logic [1:0] {
        PH_WIDTH  = 2'd0,
        PH_HEIGHT = 2'd1,
        PH_PIXEL  = 2'd2
    } t_phase;

    // One classified pixel command, front to back
    typedef struct packed {
        logic [SX_W-1:0] sx;
        logic [SY_W-1:0] sy;
        logic            on_screen;
        logic            enable;
        logic [7:0]      pixel;
        logic            done;
    } t_cmd;

endpackage

// ===== rtl/sprite_blit_color_key_clip.sv =====
// Color-keyed sprite blitter with right/bottom clipping.
// An accepted pixel byte is first written into the queue, then goes through the
// address multiply into the output register once that register is free or popped.
// Throughput: one byte per cycle; full rises only once the queue has filled
// behind a stalled output register.
// Reset (synchronous, i_rst_n low): parser waits for a width byte, queue and
// output register empty.
`timescale 1ns / 1ps

module sprite_blit_color_key_clip #(
    parameter int unsigned SCREEN_WIDTH  = 320,
    parameter int unsigned SCREEN_HEIGHT = 200,
    parameter int unsigned QUEUE_DEPTH   = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_req_type,
    input  logic [8:0]  i_origin_x,
    input  logic [7:0]  i_origin_y,
    input  logic [7:0]  i_stream_byte,
    input  logic        i_first_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_write_enable,
    output logic [15:0] o_write_addr,
    output logic [7:0]  o_write_pixel,
    output logic        o_sprite_done
);

    logic          accept;
    logic          front_valid;
    sbc_pkg::t_cmd front_cmd;
    logic          q_valid;
    logic          q_full;
    logic          q_take;
    sbc_pkg::t_cmd q_cmd;

    assign accept = push && !q_full;
    assign full   = q_full;

    sbc_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_req_type    (i_req_type),
        .i_origin_x    (i_origin_x),
        .i_origin_y    (i_origin_y),
        .i_stream_byte (i_stream_byte),
        .i_first_byte  (i_first_byte),
        .o_cmd_valid   (front_valid),
        .o_cmd         (front_cmd)
    );

    sbc_fifo #(
        .WIDTH (int'($bits(sbc_pkg::t_cmd))),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (front_valid),
        .i_wr_data (front_cmd),
        .i_rd      (q_take),
        .o_rd_data (q_cmd),
        .o_valid   (q_valid),
        .o_full    (q_full)
    );

    sbc_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (q_valid),
        .i_cmd          (q_cmd),
        .o_cmd_take     (q_take),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_write_enable (o_write_enable),
        .o_write_addr   (o_write_addr),
        .o_write_pixel  (o_write_pixel),
        .o_sprite_done  (o_sprite_done)
    );

`ifndef ASSERT_OFF
    // a pixel command is only produced for an accepted word
    a_cmd_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_valid |-> !q_full)
        else $error("pixel command produced while queue full");

    // an idle output register picks up a waiting command at once
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && q_valid) |=> !empty)
        else $error("output register idle while queue holds a command");

    // a queued command leaves only into a free or draining output register
    a_take_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_take |-> (empty || pop))
        else $error("command taken while output register stalled");
`endif

endmodule

// ===== rtl/sbc_front.sv =====
// Front end: parses the sprite byte stream, walks column/row counters and
// classifies each pixel (clip, transparency). Depends on sbc_pkg.
`timescale 1ns / 1ps

module sbc_front #(
    parameter int unsigned SCREEN_WIDTH  = 320,
    parameter int unsigned SCREEN_HEIGHT = 200
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_req_type,
    input  logic [8:0]        i_origin_x,
    input  logic [7:0]        i_origin_y,
    input  logic [7:0]        i_stream_byte,
    input  logic              i_first_byte,
    output logic              o_cmd_valid,
    output sbc_pkg::t_cmd     o_cmd
);

    sbc_pkg::t_phase r_phase, n_phase;
    logic [7:0] r_width, n_width;
    logic [7:0] r_height, n_height;
    logic [7:0] r_col, n_col;
    logic [7:0] r_row, n_row;
    logic [8:0] r_x, n_x;
    logic [7:0] r_y, n_y;
    logic       r_mode, n_mode;

    logic [sbc_pkg::SX_W-1:0] sx;
    logic [sbc_pkg::SY_W-1:0] sy;
    logic                     on_screen;
    logic                     col_last;
    logic                     row_last;

    always_comb begin
        sx        = {1'b0, r_x} + {2'b00, r_col};
        sy        = {1'b0, r_y} + {1'b0, r_row};
        on_screen = (32'(sx) < 32'(SCREEN_WIDTH)) && (32'(sy) < 32'(SCREEN_HEIGHT));
        col_last  = ({1'b0, r_col} + 9'd1) >= {1'b0, r_width};
        row_last  = ({1'b0, r_row} + 9'd1) >= {1'b0, r_height};

        o_cmd.sx        = sx;
        o_cmd.sy        = sy;
        o_cmd.on_screen = on_screen;
        o_cmd.enable    = on_screen &&
                          (r_mode || (i_stream_byte != sbc_pkg::TRANSPARENT_COLOR));
        o_cmd.pixel     = r_mode ? 8'd0 : i_stream_byte;
        o_cmd.done      = col_last && row_last;
        o_cmd_valid     = i_accept && !i_first_byte && (r_phase == sbc_pkg::PH_PIXEL);
    end

    always_comb begin
        n_phase  = r_phase;
        n_width  = r_width;
        n_height = r_height;
        n_col    = r_col;
        n_row    = r_row;
        n_x      = r_x;
        n_y      = r_y;
        n_mode   = r_mode;
        if (i_accept) begin
            if (i_first_byte) begin
                // a width byte always restarts, even mid-sprite
                n_width = i_stream_byte;
                n_x     = i_origin_x;
                n_y     = i_origin_y;
                n_mode  = i_req_type;
                n_col   = 8'd0;
                n_row   = 8'd0;
                n_phase = sbc_pkg::PH_HEIGHT;
            end else begin
                unique case (r_phase)
                    sbc_pkg::PH_HEIGHT: begin
                        n_height = i_stream_byte;
                        n_col    = 8'd0;
                        n_row    = 8'd0;
                        n_phase  = (r_width == 8'd0 || i_stream_byte == 8'd0) ?
                                   sbc_pkg::PH_WIDTH : sbc_pkg::PH_PIXEL;
                    end
                    sbc_pkg::PH_PIXEL: begin
                        if (col_last) begin
                            n_col = 8'd0;
                            if (row_last) begin
                                n_row   = 8'd0;
                                n_phase = sbc_pkg::PH_WIDTH;
                            end else begin
                                n_row = r_row + 8'd1;
                            end
                        end else begin
                            n_col = r_col + 8'd1;
                        end
                    end
                    default: begin
                        n_phase = sbc_pkg::PH_WIDTH;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sbc_pkg::PH_WIDTH;
            r_col   <= 8'd0;
            r_row   <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_width  <= n_width;
        r_height <= n_height;
        r_x      <= n_x;
        r_y      <= n_y;
        r_mode   <= n_mode;
    end

endmodule

// ===== rtl/sbc_fifo.sv =====
// Small register queue that decouples the front end from the back end.
// Generic width and depth; no package dependencies.
`timescale 1ns / 1ps

module sbc_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_valid,
    output logic             o_full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_wr, do_rd;

    always_comb begin
        o_valid   = (r_cnt != '0);
        o_full    = (r_cnt == CNT_W'(DEPTH));
        o_rd_data = r_mem[r_rd_ptr];
        do_wr     = i_wr && !o_full;
        do_rd     = i_rd && o_valid;

        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        n_cnt = r_cnt + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// ===== rtl/sbc_back.sv =====
// Back end: turns a classified pixel command into a framebuffer write word
// (linear address) and holds it in the output register. Depends on sbc_pkg.
`timescale 1ns / 1ps

module sbc_back #(
    parameter int unsigned SCREEN_WIDTH = 320
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  sbc_pkg::t_cmd              i_cmd,
    output logic                       o_cmd_take,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic                       o_write_enable,
    output logic [sbc_pkg::ADDR_W-1:0] o_write_addr,
    output logic [7:0]                 o_write_pixel,
    output logic                       o_sprite_done
);

    logic                       r_valid, n_valid;
    logic                       r_en;
    logic [sbc_pkg::ADDR_W-1:0] r_addr;
    logic [7:0]                 r_pix;
    logic                       r_done;

    logic [31:0]                row_base;
    logic [sbc_pkg::ADDR_W-1:0] addr;

    always_comb begin
        row_base   = 32'(i_cmd.sy) * 32'(SCREEN_WIDTH);
        // address wraps modulo 2^16; clipped pixels report zero
        addr       = i_cmd.on_screen ? sbc_pkg::ADDR_W'(row_base + 32'(i_cmd.sx)) : '0;
        o_cmd_take = i_cmd_valid && (!r_valid || i_pop);
        n_valid    = o_cmd_take ? 1'b1 : (i_pop ? 1'b0 : r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_en   <= i_cmd.enable;
            r_addr <= addr;
            r_pix  <= i_cmd.pixel;
            r_done <= i_cmd.done;
        end
    end

    assign o_empty        = !r_valid;
    assign o_write_enable = r_en;
    assign o_write_addr   = r_addr;
    assign o_write_pixel  = r_pix;
    assign o_sprite_done  = r_done;

endmodule
